[sv/mctt_pkg.sv]
package mctt_pkg;

  // bank size and counter width
  localparam int NumTimers  = 8;
  localparam int CountWidth = 16;

  // fixed field widths
  localparam int ModeW  = 2;
  localparam int IdW    = 3;
  localparam int DurW   = 16;
  localparam int MaskW  = 8;
  localparam int TickW  = 8;

  typedef enum logic [ModeW-1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_KILL  = 2'd2,
    MODE_QUERY = 2'd3
  } mode_e;

  // controller to datapath
  typedef struct packed {
    logic capture;  // take the input beat into the operand registers
    logic commit;   // apply the operation and load the result register
  } cmd_t;

endpackage

[sv/mctt_if.sv]
interface mctt_in_if;
  logic                           valid;
  logic                           ready;
  logic [mctt_pkg::ModeW-1:0]     mode;
  logic [mctt_pkg::IdW-1:0]       timer_id;
  logic [mctt_pkg::DurW-1:0]      duration;

  modport source (output valid, mode, timer_id, duration, input ready);
  modport sink   (input valid, mode, timer_id, duration, output ready);
endinterface

interface mctt_out_if;
  logic                           valid;
  logic                           ready;
  logic [mctt_pkg::MaskW-1:0]     expired_mask;
  logic [mctt_pkg::MaskW-1:0]     running_mask;
  logic                           selected_expired;
  logic [mctt_pkg::TickW-1:0]     tick_count;

  modport source (output valid, expired_mask, running_mask, selected_expired, tick_count,
                  input ready);
  modport sink   (input valid, expired_mask, running_mask, selected_expired, tick_count,
                  output ready);
endinterface

[sv/mctt_ctrl.sv]
module mctt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output mctt_pkg::cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_accept;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  // result register can take a new beat when empty or draining this cycle
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.capture = in_accept;
    cmd_o.commit  = 1'b0;
    state_d       = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_state_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state not one-hot");

  a_accept_to_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_EXEC))
    else $error("accepted beat did not start execution");

  a_commit_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("committed result not presented");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while held");

endmodule

[sv/mctt_dp.sv]
module mctt_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mctt_pkg::cmd_t                cmd_i,
  input  logic [mctt_pkg::ModeW-1:0]    mode_i,
  input  logic [mctt_pkg::IdW-1:0]      timer_id_i,
  input  logic [mctt_pkg::DurW-1:0]     duration_i,
  output logic [mctt_pkg::MaskW-1:0]    expired_mask_o,
  output logic [mctt_pkg::MaskW-1:0]    running_mask_o,
  output logic                          selected_expired_o,
  output logic [mctt_pkg::TickW-1:0]    tick_count_o
);

  localparam int N = mctt_pkg::NumTimers;
  localparam int W = mctt_pkg::CountWidth;

  // operand registers
  mctt_pkg::mode_e               mode_q;
  logic [mctt_pkg::IdW-1:0]      id_q;
  logic [mctt_pkg::DurW-1:0]     dur_q;

  // timer state
  logic [N-1:0]                  enable_q, enable_d;
  logic [N-1:0]                  timeout_q, timeout_d;
  logic [mctt_pkg::TickW-1:0]    tick_q, tick_d;
  logic [W-1:0]                  cnt_q [N];
  logic [W-1:0]                  cnt_d [N];

  // result register
  logic [mctt_pkg::MaskW-1:0]    exp_mask_q, exp_mask_d;
  logic [mctt_pkg::MaskW-1:0]    run_mask_q, run_mask_d;
  logic                          sel_q, sel_d;

  logic [N-1:0]                  sel_oh;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      sel_oh[i] = (int'(id_q) == i);
    end
  end

  always_comb begin
    enable_d  = enable_q;
    timeout_d = timeout_q;
    tick_d    = tick_q;
    for (int i = 0; i < N; i++) begin
      cnt_d[i] = cnt_q[i];
    end
    case (mode_q)
      mctt_pkg::MODE_TICK: begin
        tick_d = tick_q + 1'b1;
        for (int i = 0; i < N; i++) begin
          if (enable_q[i]) begin
            cnt_d[i] = cnt_q[i] - 1'b1;
            if (cnt_d[i] == '0) begin
              timeout_d[i] = 1'b1;
              enable_d[i]  = 1'b0;
            end
          end
        end
      end
      mctt_pkg::MODE_START: begin
        for (int i = 0; i < N; i++) begin
          if (sel_oh[i]) begin
            cnt_d[i]     = W'(dur_q);
            enable_d[i]  = 1'b1;
            timeout_d[i] = 1'b0;
          end
        end
      end
      mctt_pkg::MODE_KILL: begin
        enable_d  = enable_q & ~sel_oh;
        timeout_d = timeout_q & ~sel_oh;
      end
      default: begin
        // query only reports
      end
    endcase

    sel_d = |(timeout_d & sel_oh);
    for (int b = 0; b < mctt_pkg::MaskW; b++) begin
      exp_mask_d[b] = (b < N) ? timeout_d[b % N] : 1'b0;
      run_mask_d[b] = (b < N) ? enable_d[b % N]  : 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mctt_pkg::mode_e'(mode_i);
      id_q   <= timer_id_i;
      dur_q  <= duration_i;
    end
    if (cmd_i.commit) begin
      for (int i = 0; i < N; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
      exp_mask_q <= exp_mask_d;
      run_mask_q <= run_mask_d;
      sel_q      <= sel_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= '0;
      timeout_q <= '0;
      tick_q    <= '0;
    end else if (cmd_i.commit) begin
      enable_q  <= enable_d;
      timeout_q <= timeout_d;
      tick_q    <= tick_d;
    end
  end

  assign expired_mask_o     = exp_mask_q;
  assign running_mask_o     = run_mask_q;
  assign selected_expired_o = sel_q;
  assign tick_count_o       = tick_q;

  a_run_xor_expired : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (enable_q & timeout_q) == '0)
    else $error("timer both running and expired");

  a_state_only_on_commit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(cmd_i.commit) |-> ($stable(enable_q) && $stable(tick_q)))
    else $error("timer state changed without commit");

endmodule

[sv/multi_channel_timeout_timer.sv]
// channel | dir | payload                                                   | beat
// in_i    | in  | mode, timer_id, duration                                  | one operation
// out_o   | out | expired_mask, running_mask, selected_expired, tick_count  | one result
//
// each operation is captured first, then executed into the result register
// a new beat is not accepted until the previous one has executed, set by the two-state controller
// execution waits while the result register holds an untaken beat
// a new beat is accepted while a finished result still waits downstream
// rst_ni clears enable and timeout flags and the tick counter; counters need no reset
module multi_channel_timeout_timer (
  input  logic        clk_i,
  input  logic        rst_ni,
  mctt_in_if.sink     in_i,
  mctt_out_if.source  out_o
);

  mctt_pkg::cmd_t cmd;

  // sequencing: capture on accept, commit when the result register is free
  mctt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  // timer bank: counters, flags, tick counter and result register
  mctt_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .mode_i             (in_i.mode),
    .timer_id_i         (in_i.timer_id),
    .duration_i         (in_i.duration),
    .expired_mask_o     (out_o.expired_mask),
    .running_mask_o     (out_o.running_mask),
    .selected_expired_o (out_o.selected_expired),
    .tick_count_o       (out_o.tick_count)
  );

endmodule
